>>> hw/rtl/thd_pkg.sv
// ============================================================================
// thd_pkg - shared types and constants for the touch hysteresis debouncer
// Register map, sequencer states and controller/datapath interface structs.
// ============================================================================
package thd_pkg;

   localparam int unsigned SAMPLE_W  = 16;
   localparam int unsigned COUNT_W   = 8;
   localparam int unsigned WEIGHT_W  = 8;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 16;
   localparam int unsigned PROD_W    = SAMPLE_W + WEIGHT_W;
   localparam int unsigned DIVR_W    = WEIGHT_W + 1;
   localparam int unsigned DIV_STEPS = SAMPLE_W;
   localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

   localparam logic [SAMPLE_W-1:0] REF_OFFSET = SAMPLE_W'(10000);

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD     = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_HYSTERESIS    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_REQUIRED      = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_AVG_WEIGHT    = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_USE_REFERENCE = CSR_IDX_W'(4);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SUM,
      ST_DIV,
      ST_UPDATE,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_req;
      logic prep;
      logic sum;
      logic div_step;
      logic update;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic value_eq_avg;
   } status_type;

endpackage

>>> hw/rtl/touch_hysteresis_debouncer_top.sv
// One raw touch reading per transaction goes in and exactly one result comes
// out: the debounced touch flag and the running average after that reading.
// A transaction runs from acceptance to result through accept, prepare,
// sum, a one-bit-per-cycle restoring divider for the (w+1) divisor,
// update and output; a reading equal to the stored average skips the
// divider. The block takes one reading at a time. The result sits in an
// output register, so the next reading is taken while a result waits.
// Config writes are taken every cycle and belong only to idle periods.
// ============================================================================
// touch_hysteresis_debouncer_top - touch channel averaging and debounce
// Sequencer plus datapath; valid/ready request, response and CSR channels.
// ============================================================================
module touch_hysteresis_debouncer_top (
   input  logic                              clock,
   input  logic                              reset,
   // CSR write channel
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [thd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [thd_pkg::CSR_DAT_W-1:0]     csr_wdata,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [thd_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic [thd_pkg::SAMPLE_W-1:0]      req_reference_sample,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_active,
   output logic [thd_pkg::SAMPLE_W-1:0]      rsp_filtered_value
);

   thd_pkg::cmd_type    cmd;
   thd_pkg::status_type status;

   // register writes never stall
   assign csr_ready = 1'b1;

   thd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   thd_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_valid && csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_sample           (req_sample),
      .req_reference_sample (req_reference_sample),
      .cmd                  (cmd),
      .status               (status),
      .rsp_active           (rsp_active),
      .rsp_filtered_value   (rsp_filtered_value)
   );

`ifndef NO_ASSERTIONS
   // one transaction in flight: no second acceptance right after one
   a_single_inflight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while previous transaction in flight");

   // a result only appears out of the working states
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response raised from idle");

   // no result in the cycle right after acceptance
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !$rose(rsp_valid))
      else $error("response raised without processing");
`endif

endmodule

>>> hw/rtl/thd_ctrl.sv
// ============================================================================
// thd_ctrl - sequencer for the touch hysteresis debouncer
// Steps one transaction through prepare, sum, serial divide, update, output.
// ============================================================================
module thd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  thd_pkg::status_type status,
   output thd_pkg::cmd_type    cmd
);

   thd_pkg::state_type                  state_ff, state_in;
   logic [thd_pkg::STEP_W-1:0]          step_ff, step_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                slot_free;
   logic                                last_step;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign last_step = (step_ff == thd_pkg::STEP_W'(thd_pkg::DIV_STEPS - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         thd_pkg::ST_IDLE: begin
            if (req_valid) state_in = thd_pkg::ST_PREP;
         end
         thd_pkg::ST_PREP: begin
            state_in = status.value_eq_avg ? thd_pkg::ST_OUT : thd_pkg::ST_SUM;
         end
         thd_pkg::ST_SUM: begin
            state_in = thd_pkg::ST_DIV;
         end
         thd_pkg::ST_DIV: begin
            if (last_step) state_in = thd_pkg::ST_UPDATE;
         end
         thd_pkg::ST_UPDATE: begin
            state_in = thd_pkg::ST_OUT;
         end
         thd_pkg::ST_OUT: begin
            if (slot_free) state_in = thd_pkg::ST_IDLE;
         end
         default: begin
            state_in = thd_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      step_in   = step_ff;
      case (state_ff)
         thd_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         thd_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
         end
         thd_pkg::ST_SUM: begin
            cmd.sum = 1'b1;
            step_in = '0;
         end
         thd_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + thd_pkg::STEP_W'(1);
         end
         thd_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         thd_pkg::ST_OUT: begin
            cmd.load_rsp = slot_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= thd_pkg::ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hw/rtl/thd_dp.sv
// ============================================================================
// thd_dp - datapath for the touch hysteresis debouncer
// Config registers, reference offset, weighted sum, restoring divider,
// confirm counter and result register.
// ============================================================================
module thd_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [thd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [thd_pkg::CSR_DAT_W-1:0]      csr_wdata,
   input  logic [thd_pkg::SAMPLE_W-1:0]       req_sample,
   input  logic [thd_pkg::SAMPLE_W-1:0]       req_reference_sample,
   input  thd_pkg::cmd_type                   cmd,
   output thd_pkg::status_type                status,
   output logic                               rsp_active,
   output logic [thd_pkg::SAMPLE_W-1:0]       rsp_filtered_value
);

   localparam int unsigned SW = thd_pkg::SAMPLE_W;
   localparam int unsigned CW = thd_pkg::COUNT_W;
   localparam int unsigned WW = thd_pkg::WEIGHT_W;
   localparam int unsigned PW = thd_pkg::PROD_W;
   localparam int unsigned DW = thd_pkg::DIVR_W;

   // config
   logic [SW-1:0] threshold_ff, hysteresis_ff;
   logic [CW-1:0] required_ff;
   logic [WW-1:0] weight_ff;
   logic          use_ref_ff;

   // working registers
   logic [SW-1:0] sample_ff, refs_ff;
   logic [SW-1:0] value_ff, value_in;
   logic [PW-1:0] prod_ff;
   logic [DW-1:0] rem_ff, rem_in;
   logic [SW-1:0] quo_ff, quo_in;
   logic [PW-1:0] dividend;
   logic [DW-1:0] divisor;
   logic [DW:0]   trial;
   logic [DW:0]   trial_diff;
   logic          trial_ge;

   // state
   logic [SW-1:0] avg_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          touched_ff, touched_in;
   logic          above_band, below_band;

   logic          rsp_active_ff;
   logic [SW-1:0] rsp_value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= '0;
         hysteresis_ff <= '0;
         required_ff   <= CW'(1);
         weight_ff     <= '0;
         use_ref_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            thd_pkg::REG_THRESHOLD:     threshold_ff  <= csr_wdata[SW-1:0];
            thd_pkg::REG_HYSTERESIS:    hysteresis_ff <= csr_wdata[SW-1:0];
            thd_pkg::REG_REQUIRED:      required_ff   <= csr_wdata[CW-1:0];
            thd_pkg::REG_AVG_WEIGHT:    weight_ff     <= csr_wdata[WW-1:0];
            thd_pkg::REG_USE_REFERENCE: use_ref_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // reference mode: sample + offset - reference, mod 2^16
   assign value_in = use_ref_ff ? (sample_ff + thd_pkg::REF_OFFSET - refs_ff) : sample_ff;
   assign status.value_eq_avg = (value_in == avg_ff);

   assign dividend = prod_ff + PW'(value_ff);
   assign divisor  = DW'(weight_ff) + DW'(1);

   // one restoring step; remainder stays below divisor
   assign trial      = {rem_ff, quo_ff[SW-1]};
   assign trial_diff = trial - {1'b0, divisor};
   assign trial_ge   = (trial >= {1'b0, divisor});

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.sum) begin
         // quotient fits 16 bits, so the top byte is already below the divisor
         rem_in = DW'(dividend[PW-1:SW]);
         quo_in = dividend[SW-1:0];
      end else if (cmd.div_step) begin
         rem_in = trial_ge ? trial_diff[DW-1:0] : trial[DW-1:0];
         quo_in = {quo_ff[SW-2:0], trial_ge};
      end
   end

   // band checks on the new average
   assign above_band = ({1'b0, quo_ff} > ({1'b0, threshold_ff} + {1'b0, hysteresis_ff}));
   assign below_band = (({1'b0, quo_ff} + {1'b0, hysteresis_ff}) < {1'b0, threshold_ff});

   always_comb begin
      cnt_in = cnt_ff;
      if (touched_ff) begin
         if (below_band && (cnt_ff != '0)) cnt_in = cnt_ff - CW'(1);
      end else begin
         if (above_band && (cnt_ff < required_ff)) cnt_in = cnt_ff + CW'(1);
      end
      if (cnt_in >= required_ff) touched_in = 1'b1;
      else if (cnt_in == '0) touched_in = 1'b0;
      else touched_in = touched_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff     <= '0;
         cnt_ff     <= '0;
         touched_ff <= 1'b0;
      end else if (cmd.update) begin
         avg_ff     <= quo_ff;
         cnt_ff     <= cnt_in;
         touched_ff <= touched_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         sample_ff <= req_sample;
         refs_ff   <= req_reference_sample;
      end
      if (cmd.prep) begin
         value_ff <= value_in;
         prod_ff  <= weight_ff * avg_ff;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (cmd.load_rsp) begin
         rsp_active_ff <= touched_ff;
         rsp_value_ff  <= avg_ff;
      end
   end

   assign rsp_active         = rsp_active_ff;
   assign rsp_filtered_value = rsp_value_ff;

endmodule
